FILE: hw/rtl/mmc3_pkg.sv
// shared types, codes and constants of the mmc3 bank mapper
package mmc3_pkg;

  localparam int PRG_RAM_BYTES = 8192;
  localparam int RAM_DEPTH     = (PRG_RAM_BYTES < 8192) ? PRG_RAM_BYTES : 8192;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);

  localparam logic [2:0] OP_CPU_READ  = 3'd0;
  localparam logic [2:0] OP_CPU_WRITE = 3'd1;
  localparam logic [2:0] OP_PPU_READ  = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_IRQ_ACK   = 3'd4;

  localparam logic [1:0] GRP_BANK   = 2'd0;
  localparam logic [1:0] GRP_MIRROR = 2'd1;
  localparam logic [1:0] GRP_RELOAD = 2'd2;
  localparam logic [1:0] GRP_IRQ_EN = 2'd3;

  localparam logic [7:0] PRG_COUNT_RESET = 8'd16;

  typedef struct packed {
    logic        mapped;
    logic        from_ram;
    logic [21:0] rom_address;
    logic        ram_read;
    logic        irq_line;
    logic        mirror_horizontal;
  } res_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  // fold a 13-bit window offset onto a smaller work ram
  function automatic logic [RAM_AW-1:0] ram_index(input logic [12:0] offs);
    logic [13:0] v;
    v = {1'b0, offs};
    for (int i = 0; i < 4; i++) begin
      if (v >= 14'(RAM_DEPTH)) begin
        v = v - 14'(RAM_DEPTH);
      end
    end
    return v[RAM_AW-1:0];
  endfunction

endpackage

FILE: hw/rtl/mmc3_bank_mapper.sv
// Cartridge bank mapper with scanline irq counter. One bus beat (cpu read,
// cpu write, ppu read, scanline tick or irq acknowledge) is accepted every
// clock unless the output stalls: the first stage decodes the beat,
// updates the mapper registers and issues the single work ram access,
// the second registers the ram read data into the output stage. Throughput
// is one beat per cycle while out_ready holds, set by the one access per
// beat on the work ram port; a stalled output holds one result and one more
// beat in flight. Work ram powers up with unknown contents, never cleared.
// prg_rom_16k_count may be written only while no beat is in flight.
module mmc3_bank_mapper import mmc3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  prg_rom_16k_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        mapped,
  output logic        from_ram,
  output logic [21:0] rom_address,
  output logic [7:0]  read_data,
  output logic        irq_line,
  output logic        mirror_horizontal
);

  res_t       res;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       in_beat;
  logic       s1_valid;
  res_t       s1_res;
  logic       s1_adv;
  logic       s2_valid;
  res_t       s2_res;
  logic [7:0] s2_rdata;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!s2_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_beat   = in_valid && in_ready;

  mmc3_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (prg_rom_16k_count),
    .beat       (in_beat),
    .op         (op),
    .address    (address),
    .write_data (write_data),
    .res        (res),
    .ram_req    (ram_req)
  );

  mmc3_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
    if (in_beat) begin
      s1_res <= res;
    end
    // ram data lines up with the beat held in the first stage
    if (s1_adv) begin
      s2_res   <= s1_res;
      s2_rdata <= s1_res.ram_read ? ram_rdata : 8'd0;
    end
  end

  assign out_valid         = s2_valid;
  assign mapped            = s2_res.mapped;
  assign from_ram          = s2_res.from_ram;
  assign rom_address       = s2_res.rom_address;
  assign read_data         = s2_rdata;
  assign irq_line          = s2_res.irq_line;
  assign mirror_horizontal = s2_res.mirror_horizontal;

  // a held first stage must not lose its ram read data
  a_rdata_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_res.ram_read && !s1_adv |=> $stable(ram_rdata))
    else $error("ram read data changed under a held beat");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    in_beat && op == OP_IRQ_ACK |=> !s1_res.irq_line)
    else $error("irq acknowledge left irq pending");

  a_ram_claimed: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_res.from_ram |-> s1_res.mapped && s1_res.rom_address == 22'd0)
    else $error("work ram beat carries a rom address or is unclaimed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !in_ready)
    else $error("beat accepted over a held first stage");

endmodule

FILE: hw/rtl/mmc3_ram.sv
// generic single port ram with registered read
module mmc3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/mmc3_ctrl.sv
// mapper registers, address decode and translation, irq counter
module mmc3_ctrl import mmc3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       beat,
  input  logic [2:0] op,
  input  logic [15:0] address,
  input  logic [7:0] write_data,
  output res_t       res,
  output ram_req_t   ram_req
);

  logic [7:0] prg_count;
  logic [7:0] bank_data [8];
  logic [2:0] bank_select;
  logic       prg_mode_pending;
  logic       chr_invert_pending;
  logic       prg_mode_active;
  logic [5:0] prg_sw_lo;
  logic [5:0] prg_sw_hi;
  logic [7:0] chr_windows [8];
  logic       nt_mirror;
  logic [7:0] irq_latch;
  logic [7:0] irq_count;
  logic       irq_enabled;
  logic       irq_pending;

  logic [7:0] bank_data_next [8];
  logic [2:0] bank_select_next;
  logic       prg_mode_pending_next;
  logic       chr_invert_pending_next;
  logic       prg_mode_active_next;
  logic [5:0] prg_sw_lo_next;
  logic [5:0] prg_sw_hi_next;
  logic [7:0] chr_windows_next [8];
  logic       nt_mirror_next;
  logic [7:0] irq_latch_next;
  logic [7:0] irq_count_next;
  logic       irq_enabled_next;
  logic       irq_pending_next;

  logic       is_cpu;
  logic       in_ram;
  logic       in_reg;
  logic       odd;
  logic [1:0] grp;
  logic [1:0] slot;
  logic [8:0] last2;
  logic [8:0] last1;
  logic [8:0] win_bank;
  logic [7:0] lo0;
  logic [7:0] lo1;
  logic [2:0] base;
  logic [7:0] chr_sel;

  always_comb begin
    is_cpu = (op == OP_CPU_READ) || (op == OP_CPU_WRITE);
    in_ram = (address[15:13] == 3'b011);
    in_reg = address[15];
    odd    = address[0];
    grp    = address[14:13];
    slot   = address[14:13];
    last2  = {prg_count, 1'b0} - 9'd2;
    last1  = {prg_count, 1'b0} - 9'd1;

    case (slot)
      2'd0:    win_bank = prg_mode_active ? last2 : {3'b000, prg_sw_lo};
      2'd1:    win_bank = {3'b000, prg_sw_hi};
      2'd2:    win_bank = prg_mode_active ? {3'b000, prg_sw_lo} : last2;
      default: win_bank = last1;
    endcase
    chr_sel = chr_windows[address[12:10]];

    bank_data_next          = bank_data;
    bank_select_next        = bank_select;
    prg_mode_pending_next   = prg_mode_pending;
    chr_invert_pending_next = chr_invert_pending;
    prg_mode_active_next    = prg_mode_active;
    prg_sw_lo_next          = prg_sw_lo;
    prg_sw_hi_next          = prg_sw_hi;
    chr_windows_next        = chr_windows;
    nt_mirror_next          = nt_mirror;
    irq_latch_next          = irq_latch;
    irq_count_next          = irq_count;
    irq_enabled_next        = irq_enabled;
    irq_pending_next        = irq_pending;

    res = '0;
    ram_req.en    = 1'b0;
    ram_req.we    = (op == OP_CPU_WRITE);
    ram_req.addr  = ram_index(address[12:0]);
    ram_req.wdata = write_data;

    lo0  = '0;
    lo1  = '0;
    base = '0;

    if (is_cpu) begin
      if (in_ram) begin
        res.mapped   = 1'b1;
        res.from_ram = 1'b1;
        res.ram_read = (op == OP_CPU_READ);
        ram_req.en   = beat;
      end else if (in_reg) begin
        if (op == OP_CPU_READ) begin
          res.mapped      = 1'b1;
          res.rom_address = {win_bank, address[12:0]};
        end else begin
          case (grp)
            GRP_BANK: begin
              if (!odd) begin
                bank_select_next        = write_data[2:0];
                prg_mode_pending_next   = write_data[6];
                chr_invert_pending_next = write_data[7];
              end else begin
                bank_data_next[bank_select] = write_data;
                lo0  = {bank_data_next[0][7:1], 1'b0};
                lo1  = {bank_data_next[1][7:1], 1'b0};
                base = chr_invert_pending ? 3'd4 : 3'd0;
                chr_windows_next[base]        = lo0;
                chr_windows_next[base + 3'd1] = lo0 + 8'd1;
                chr_windows_next[base + 3'd2] = lo1;
                chr_windows_next[base + 3'd3] = lo1 + 8'd1;
                for (int i = 0; i < 4; i++) begin
                  chr_windows_next[(base ^ 3'd4) + 3'(i)] = bank_data_next[3'(i + 2)];
                end
                prg_mode_active_next = prg_mode_pending;
                prg_sw_lo_next       = bank_data_next[6][5:0];
                prg_sw_hi_next       = bank_data_next[7][5:0];
              end
            end
            GRP_MIRROR: begin
              if (!odd) begin
                nt_mirror_next = write_data[0];
              end
            end
            GRP_RELOAD: begin
              if (!odd) begin
                irq_latch_next = write_data;
              end else begin
                irq_count_next = '0;
              end
            end
            default: begin
              if (!odd) begin
                irq_enabled_next = 1'b0;
                irq_pending_next = 1'b0;
              end else begin
                irq_enabled_next = 1'b1;
              end
            end
          endcase
        end
      end
    end else if (op == OP_PPU_READ) begin
      if (address[15:13] == 3'b000) begin
        res.mapped      = 1'b1;
        res.rom_address = {4'b0000, chr_sel, address[9:0]};
      end
    end else if (op == OP_TICK) begin
      irq_count_next = (irq_count == 8'd0) ? irq_latch : irq_count - 8'd1;
      if (irq_count_next == 8'd0 && irq_enabled) begin
        irq_pending_next = 1'b1;
      end
    end else if (op == OP_IRQ_ACK) begin
      irq_pending_next = 1'b0;
    end

    res.irq_line          = irq_pending_next;
    res.mirror_horizontal = nt_mirror_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count          <= PRG_COUNT_RESET;
      bank_data          <= '{default: '0};
      bank_select        <= '0;
      prg_mode_pending   <= 1'b0;
      chr_invert_pending <= 1'b0;
      prg_mode_active    <= 1'b0;
      prg_sw_lo          <= 6'd0;
      prg_sw_hi          <= 6'd1;
      chr_windows        <= '{default: '0};
      nt_mirror          <= 1'b1;
      irq_latch          <= '0;
      irq_count          <= '0;
      irq_enabled        <= 1'b0;
      irq_pending        <= 1'b0;
    end else begin
      if (cfg_we) begin
        prg_count <= cfg_data;
      end
      if (beat) begin
        bank_data          <= bank_data_next;
        bank_select        <= bank_select_next;
        prg_mode_pending   <= prg_mode_pending_next;
        chr_invert_pending <= chr_invert_pending_next;
        prg_mode_active    <= prg_mode_active_next;
        prg_sw_lo          <= prg_sw_lo_next;
        prg_sw_hi          <= prg_sw_hi_next;
        chr_windows        <= chr_windows_next;
        nt_mirror          <= nt_mirror_next;
        irq_latch          <= irq_latch_next;
        irq_count          <= irq_count_next;
        irq_enabled        <= irq_enabled_next;
        irq_pending        <= irq_pending_next;
      end
    end
  end

endmodule
